/* sv/first_fit_block_allocator_unit_macros.svh */
// Assertion shorthands shared by the allocator modules.
// Each expects clk and rst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffa assertion failed");

// next-cycle implication
`define FFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffa assertion failed");

`endif

/* sv/ffa_pkg.sv */
package ffa_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W       = 32;
    localparam int SUM_W        = DATA_W + 2;
    localparam int HEADER_BYTES = 4;
    localparam int HANDLE_BYTES = 8;
    localparam int ALIGN_BYTES  = 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOFIT  = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_DOUBLE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;

    localparam logic [1:0] TCMD_NONE   = 2'd0;
    localparam logic [1:0] TCMD_WRITE  = 2'd1;
    localparam logic [1:0] TCMD_INSERT = 2'd2;
    localparam logic [1:0] TCMD_REMOVE = 2'd3;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] request_size;
        logic [DATA_W-1:0] user_address;
        logic [DATA_W-1:0] header_size;
    } ffa_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] granted_address;
        logic [DATA_W-1:0] granted_size;
    } ffa_rsp_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] size;
    } ffa_tcmd_t;

endpackage

/* sv/first_fit_block_allocator_unit.sv */
// First-fit block allocator with coalescing.
// Requests arrive on req_valid/req_ready: op selects allocate or free. Results
// leave on rsp_valid/rsp_ready, one per request, carrying status, the granted
// user address and the granted block size (both zero unless an allocate is ok).
// The region is set through cfg_write/cfg_index/cfg_data; any write to the
// start or size register rebuilds the free table at once. Write only while idle.
// One request is in flight at a time, walked by a sequencer over one shared
// 34-bit adder and a 16-entry free table that is read one entry per cycle.
// An allocate rounds the size up, adds the header, scans the table for the
// first fitting entry and splits or removes it; a free checks its range, scans
// for its place and inserts or merges. A free that fails the range check skips
// the scan; one that is already free ends its scan at the entry holding it.
// req_ready rises with rsp_valid; a new request is taken once the last is done.
// req_ready is high only while idle; a finished result sits in the output
// register, so the next request is taken while it waits. If the receiver stalls
// and a second result is done, the sequencer holds it until the first is taken.
// Reset clears both region registers, leaving the table empty; no request
// is taken before reset is released.
`include "first_fit_block_allocator_unit_macros.svh"

module first_fit_block_allocator_unit
    import ffa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ffa_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output ffa_rsp_t             rsp,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_NEED   = 4'd1;
    localparam logic [3:0] S_NEED2  = 4'd2;
    localparam logic [3:0] S_NEED8  = 4'd3;
    localparam logic [3:0] S_ASCAN  = 4'd4;
    localparam logic [3:0] S_ANEWA  = 4'd5;
    localparam logic [3:0] S_ANEWS  = 4'd6;
    localparam logic [3:0] S_AADDR  = 4'd7;
    localparam logic [3:0] S_FLO    = 4'd8;
    localparam logic [3:0] S_FHI    = 4'd9;
    localparam logic [3:0] S_FSCAN  = 4'd10;
    localparam logic [3:0] S_FSUCC  = 4'd11;
    localparam logic [3:0] S_FMSUCC = 4'd12;
    localparam logic [3:0] S_FMPRED = 4'd13;
    localparam logic [3:0] S_FREM   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [DATA_W-1:0] region_start_reg, region_start_next;
    logic [DATA_W-1:0] region_size_reg, region_size_next;
    logic              rebuild;
    logic [DATA_W-1:0] req_size_reg, req_size_next;
    logic [DATA_W-1:0] blk_reg, blk_next;
    logic [DATA_W-1:0] hsize_reg, hsize_next;
    logic [SUM_W-1:0]  need_reg, need_next;
    logic [SUM_W-1:0]  need8_reg, need8_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  pos_m1;
    logic [DATA_W-1:0] cur_a_reg, cur_a_next;
    logic [DATA_W-1:0] cur_s_reg, cur_s_next;
    logic [DATA_W-1:0] new_a_reg, new_a_next;
    logic [DATA_W-1:0] pred_a_reg, pred_a_next;
    logic [DATA_W-1:0] pred_s_reg, pred_s_next;
    logic [SUM_W-1:0]  pred_end_reg, pred_end_next;
    logic [DATA_W-1:0] succ_s_reg, succ_s_next;
    logic [SUM_W-1:0]  h2_reg, h2_next;
    logic              js_reg, js_next;
    logic              jp_reg, jp_next;
    logic [2:0]        status_reg, status_next;
    logic [DATA_W-1:0] gaddr_reg, gaddr_next;
    logic [DATA_W-1:0] gsize_reg, gsize_next;
    logic              rsp_valid_reg, rsp_valid_next;
    ffa_rsp_t          rsp_reg, rsp_next;

    logic [SUM_W-1:0]  alu_a, alu_b, alu_sum;
    logic              alu_sub;
    ffa_tcmd_t         tcmd;
    logic [DATA_W-1:0] rd_addr, rd_size;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  rd_size_w, blk_w;
    logic              js, jp;

    always_comb
    begin
        region_start_next = region_start_reg;
        region_size_next  = region_size_reg;
        rebuild           = 1'b0;
        if (cfg_write && (cfg_index inside {REG_START, REG_SIZE}))
        begin
            rebuild = 1'b1;
            if (cfg_index == REG_START)
            begin
                region_start_next = cfg_data;
            end
            else
            begin
                region_size_next = cfg_data;
            end
        end
    end

    ffa_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rebuild   (rebuild),
        .new_start (region_start_next),
        .new_size  (region_size_next),
        .cmd       (tcmd),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_addr   (rd_addr),
        .rd_size   (rd_size),
        .count     (count)
    );

    assign alu_sum   = alu_a + (alu_sub ? ~alu_b : alu_b) + SUM_W'(alu_sub);
    assign rd_size_w = SUM_W'(rd_size);
    assign blk_w     = SUM_W'(blk_reg);
    assign pos_m1    = pos_reg - CNT_W'(1);
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        req_size_next  = req_size_reg;
        blk_next       = blk_reg;
        hsize_next     = hsize_reg;
        need_next      = need_reg;
        need8_next     = need8_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        cur_a_next     = cur_a_reg;
        cur_s_next     = cur_s_reg;
        new_a_next     = new_a_reg;
        pred_a_next    = pred_a_reg;
        pred_s_next    = pred_s_reg;
        pred_end_next  = pred_end_reg;
        succ_s_next    = succ_s_reg;
        h2_next        = h2_reg;
        js_next        = js_reg;
        jp_next        = jp_reg;
        status_next    = status_reg;
        gaddr_next     = gaddr_reg;
        gsize_next     = gsize_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;
        tcmd           = '{kind: TCMD_NONE, idx: '0, addr: '0, size: '0};
        js             = 1'b0;
        jp             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                alu_a   = SUM_W'(req.user_address);
                alu_b   = SUM_W'(HEADER_BYTES);
                alu_sub = 1'b1;
                if (req_valid)
                begin
                    req_size_next = req.request_size;
                    blk_next      = alu_sum[DATA_W-1:0];
                    hsize_next    = req.header_size;
                    status_next   = ST_OK;
                    gaddr_next    = '0;
                    gsize_next    = '0;
                    state_next    = (req.op == OP_ALLOC) ? S_NEED : S_FLO;
                end
            end
            S_NEED:
            begin
                alu_a      = SUM_W'(req_size_reg);
                alu_b      = SUM_W'(ALIGN_BYTES - 1);
                need_next  = alu_sum & ~SUM_W'(ALIGN_BYTES - 1);
                state_next = S_NEED2;
            end
            S_NEED2:
            begin
                alu_a      = need_reg;
                alu_b      = SUM_W'(HEADER_BYTES);
                need_next  = alu_sum;
                state_next = S_NEED8;
            end
            S_NEED8:
            begin
                alu_a      = need_reg;
                alu_b      = SUM_W'(ALIGN_BYTES);
                need8_next = alu_sum;
                idx_next   = '0;
                state_next = S_ASCAN;
            end
            S_ASCAN:
            begin
                if (idx_reg >= count)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else if (rd_size_w >= need_reg && rd_size_w <= need8_reg)
                begin
                    cur_a_next = rd_addr;
                    gsize_next = rd_size;
                    tcmd.kind  = TCMD_REMOVE;
                    tcmd.idx   = idx_reg[IDX_W-1:0];
                    state_next = S_AADDR;
                end
                else if (rd_size_w > need8_reg)
                begin
                    cur_a_next = rd_addr;
                    cur_s_next = rd_size;
                    gsize_next = need_reg[DATA_W-1:0];
                    state_next = S_ANEWA;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_ANEWA:
            begin
                alu_a      = SUM_W'(cur_a_reg);
                alu_b      = need_reg;
                new_a_next = alu_sum[DATA_W-1:0];
                state_next = S_ANEWS;
            end
            S_ANEWS:
            begin
                alu_a      = SUM_W'(cur_s_reg);
                alu_b      = need_reg;
                alu_sub    = 1'b1;
                tcmd.kind  = TCMD_WRITE;
                tcmd.idx   = idx_reg[IDX_W-1:0];
                tcmd.addr  = new_a_reg;
                tcmd.size  = alu_sum[DATA_W-1:0];
                state_next = S_AADDR;
            end
            S_AADDR:
            begin
                alu_a      = SUM_W'(cur_a_reg);
                alu_b      = SUM_W'(HEADER_BYTES);
                gaddr_next = alu_sum[DATA_W-1:0];
                state_next = S_DONE;
            end
            S_FLO:
            begin
                alu_a = SUM_W'(region_start_reg);
                alu_b = SUM_W'(HANDLE_BYTES);
                if (blk_w < alu_sum)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FHI;
                end
            end
            S_FHI:
            begin
                alu_a    = SUM_W'(region_start_reg);
                alu_b    = SUM_W'(region_size_reg);
                idx_next = '0;
                pos_next = '0;
                if (blk_w >= alu_sum)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                alu_a = SUM_W'(rd_addr);
                alu_b = rd_size_w;
                if (idx_reg >= count)
                begin
                    idx_next   = pos_reg;
                    state_next = S_FSUCC;
                end
                else if (blk_reg >= rd_addr && blk_w < alu_sum)
                begin
                    status_next = ST_DOUBLE;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (rd_addr < blk_reg)
                    begin
                        pos_next      = idx_reg + CNT_W'(1);
                        pred_a_next   = rd_addr;
                        pred_s_next   = rd_size;
                        pred_end_next = alu_sum;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_FSUCC:
            begin
                alu_a       = blk_w;
                alu_b       = SUM_W'(hsize_reg);
                js          = (pos_reg < count) && (SUM_W'(rd_addr) == alu_sum);
                jp          = (pos_reg != '0) && (pred_end_reg == blk_w);
                js_next     = js;
                jp_next     = jp;
                succ_s_next = rd_size;
                h2_next     = SUM_W'(hsize_reg);
                if (!js && !jp)
                begin
                    if (count >= CNT_W'(TABLE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        tcmd.kind = TCMD_INSERT;
                        tcmd.idx  = pos_reg[IDX_W-1:0];
                        tcmd.addr = blk_reg;
                        tcmd.size = hsize_reg;
                    end
                    state_next = S_DONE;
                end
                else if (js)
                begin
                    state_next = S_FMSUCC;
                end
                else
                begin
                    state_next = S_FMPRED;
                end
            end
            S_FMSUCC:
            begin
                alu_a      = SUM_W'(hsize_reg);
                alu_b      = SUM_W'(succ_s_reg);
                h2_next    = alu_sum;
                tcmd.kind  = TCMD_WRITE;
                tcmd.idx   = pos_reg[IDX_W-1:0];
                tcmd.addr  = blk_reg;
                tcmd.size  = alu_sum[DATA_W-1:0];
                state_next = jp_reg ? S_FMPRED : S_DONE;
            end
            S_FMPRED:
            begin
                alu_a      = SUM_W'(pred_s_reg);
                alu_b      = h2_reg;
                tcmd.kind  = TCMD_WRITE;
                tcmd.idx   = pos_m1[IDX_W-1:0];
                tcmd.addr  = pred_a_reg;
                tcmd.size  = alu_sum[DATA_W-1:0];
                state_next = js_reg ? S_FREM : S_DONE;
            end
            S_FREM:
            begin
                tcmd.kind  = TCMD_REMOVE;
                tcmd.idx   = pos_reg[IDX_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status          = status_reg;
                    rsp_next.granted_address = gaddr_reg;
                    rsp_next.granted_size    = gsize_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            region_start_reg <= '0;
            region_size_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            region_start_reg <= region_start_next;
            region_size_reg  <= region_size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_size_reg <= req_size_next;
        blk_reg      <= blk_next;
        hsize_reg    <= hsize_next;
        need_reg     <= need_next;
        need8_reg    <= need8_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        cur_a_reg    <= cur_a_next;
        cur_s_reg    <= cur_s_next;
        new_a_reg    <= new_a_next;
        pred_a_reg   <= pred_a_next;
        pred_s_reg   <= pred_s_next;
        pred_end_reg <= pred_end_next;
        succ_s_reg   <= succ_s_next;
        h2_reg       <= h2_next;
        js_reg       <= js_next;
        jp_reg       <= jp_next;
        status_reg   <= status_next;
        gaddr_reg    <= gaddr_next;
        gsize_reg    <= gsize_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `FFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `FFA_ASSERT_IMP(a_fail_clears, rsp_valid_reg && rsp_reg.status != ST_OK,
        rsp_reg.granted_address == '0 && rsp_reg.granted_size == '0)
    `FFA_ASSERT_IMP(a_pos_behind_scan, state_reg == S_FSCAN, pos_reg <= idx_reg)

endmodule

/* sv/ffa_table.sv */
`include "first_fit_block_allocator_unit_macros.svh"

module ffa_table
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rebuild,
    input  logic [DATA_W-1:0] new_start,
    input  logic [DATA_W-1:0] new_size,
    input  ffa_tcmd_t         cmd,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [DATA_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_size,
    output logic [CNT_W-1:0]  count
);

    logic [DATA_W-1:0] addr_reg [TABLE_DEPTH];
    logic [DATA_W-1:0] size_reg [TABLE_DEPTH];
    logic [DATA_W-1:0] addr_next [TABLE_DEPTH];
    logic [DATA_W-1:0] size_next [TABLE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        addr_next  = addr_reg;
        size_next  = size_reg;
        count_next = count_reg;
        if (rebuild)
        begin
            if (new_size > DATA_W'(2 * HANDLE_BYTES))
            begin
                addr_next[0] = new_start + DATA_W'(HANDLE_BYTES);
                size_next[0] = new_size - DATA_W'(HANDLE_BYTES);
                count_next   = CNT_W'(1);
            end
            else
            begin
                count_next = '0;
            end
        end
        else
        begin
            case (cmd.kind)
                TCMD_WRITE:
                begin
                    addr_next[cmd.idx] = cmd.addr;
                    size_next[cmd.idx] = cmd.size;
                end
                TCMD_INSERT:
                begin
                    for (int j = 1; j < TABLE_DEPTH; j++)
                    begin
                        if (IDX_W'(j) > cmd.idx)
                        begin
                            addr_next[j] = addr_reg[j-1];
                            size_next[j] = size_reg[j-1];
                        end
                    end
                    addr_next[cmd.idx] = cmd.addr;
                    size_next[cmd.idx] = cmd.size;
                    count_next         = count_reg + CNT_W'(1);
                end
                TCMD_REMOVE:
                begin
                    for (int j = 0; j < TABLE_DEPTH - 1; j++)
                    begin
                        if (IDX_W'(j) >= cmd.idx)
                        begin
                            addr_next[j] = addr_reg[j+1];
                            size_next[j] = size_reg[j+1];
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        size_reg <= size_next;
    end

    assign rd_addr = addr_reg[rd_idx];
    assign rd_size = size_reg[rd_idx];
    assign count   = count_reg;

    `FFA_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `FFA_ASSERT_IMP(a_insert_room, !rebuild && cmd.kind == TCMD_INSERT,
        count_reg < CNT_W'(TABLE_DEPTH))
    `FFA_ASSERT_IMP(a_remove_live, !rebuild && cmd.kind == TCMD_REMOVE,
        CNT_W'(cmd.idx) < count_reg)

endmodule

/* verif/tb_first_fit_block_allocator_unit.sv */
module tb_first_fit_block_allocator_unit;
    import ffa_pkg::*;

    localparam int PLAN_COPY   = 0;
    localparam int CHECK_COPY  = 1;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 76;
    localparam bit [63:0] ADDR_MASK = 64'hFFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    ffa_req_t             req = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    ffa_rsp_t             rsp;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    bit [63:0]   tbl_addr [0:1][0:TABLE_DEPTH-1];
    bit [63:0]   tbl_size [0:1][0:TABLE_DEPTH-1];
    int          tbl_count [0:1];
    logic [31:0] reg_start [0:1];
    logic [31:0] reg_size [0:1];

    ffa_req_t    pending_requests[$];
    ffa_rsp_t    expected_grants[$];
    logic [31:0] live_addr[$];
    logic [31:0] live_size[$];
    logic [31:0] freed_addrs[$];

    int req_idle_pct = 20;
    int rsp_idle_pct = 20;
    int mismatches = 0;
    int results_seen = 0;
    int alloc_total = 0;
    int free_total = 0;
    int settings_run = 0;
    int outcome_tally [0:4] = '{default: 0};
    int hold_left;
    bit hold_done;
    int cycle_count;

    first_fit_block_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic void table_rebuild(int m);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_addr[m][i] = '0;
            tbl_size[m][i] = '0;
        end
        tbl_count[m] = 0;
        if (reg_size[m] > 2 * HANDLE_BYTES)
        begin
            tbl_addr[m][0] = (64'(reg_start[m]) + HANDLE_BYTES) & ADDR_MASK;
            tbl_size[m][0] = (64'(reg_size[m]) - HANDLE_BYTES) & ADDR_MASK;
            tbl_count[m] = 1;
        end
    endfunction

    function automatic void table_remove(int m, int idx);
        int j;
        for (j = idx; j + 1 < tbl_count[m]; j++)
        begin
            tbl_addr[m][j] = tbl_addr[m][j+1];
            tbl_size[m][j] = tbl_size[m][j+1];
        end
        if (tbl_count[m] > 0)
        begin
            tbl_count[m]--;
            tbl_addr[m][tbl_count[m]] = '0;
            tbl_size[m][tbl_count[m]] = '0;
        end
    endfunction

    function automatic ffa_rsp_t first_fit_outcome(int m, ffa_req_t r);
        ffa_rsp_t  res;
        bit [63:0] need, a, s, blk, lo, hi, hs;
        int        i, n, pos;
        bit        taken, twice, join_pred, join_succ;
        res = '0;
        if (r.op == OP_ALLOC)
        begin
            need = ((64'(r.request_size) + ALIGN_BYTES - 1) & ~64'(ALIGN_BYTES - 1))
                   + HEADER_BYTES;
            res.status = ST_NOFIT;
            taken = 1'b0;
            for (i = 0; i < tbl_count[m] && !taken; i++)
            begin
                a = tbl_addr[m][i];
                s = tbl_size[m][i];
                if (s >= need && s <= need + ALIGN_BYTES)
                begin
                    res.status = ST_OK;
                    res.granted_address = 32'((a + HEADER_BYTES) & ADDR_MASK);
                    res.granted_size = 32'(s);
                    table_remove(m, i);
                    taken = 1'b1;
                end
                else if (s > need + ALIGN_BYTES)
                begin
                    res.status = ST_OK;
                    res.granted_address = 32'((a + HEADER_BYTES) & ADDR_MASK);
                    res.granted_size = 32'(need);
                    tbl_addr[m][i] = (a + need) & ADDR_MASK;
                    tbl_size[m][i] = (s - need) & ADDR_MASK;
                    taken = 1'b1;
                end
            end
        end
        else
        begin
            blk = (64'(r.user_address) - HEADER_BYTES) & ADDR_MASK;
            lo = 64'(reg_start[m]) + HANDLE_BYTES;
            hi = 64'(reg_start[m]) + 64'(reg_size[m]);
            hs = 64'(r.header_size);
            n = tbl_count[m];
            pos = 0;
            twice = 1'b0;
            if (blk < lo || blk >= hi)
                res.status = ST_RANGE;
            else
            begin
                for (i = 0; i < n && !twice; i++)
                begin
                    a = tbl_addr[m][i];
                    if (blk >= a && blk < a + tbl_size[m][i])
                        twice = 1'b1;
                    else if (a < blk)
                        pos = i + 1;
                end
                if (twice)
                    res.status = ST_DOUBLE;
                else
                begin
                    join_succ = pos < n && tbl_addr[m][pos] == blk + hs;
                    join_pred = pos > 0 &&
                        tbl_addr[m][pos-1] + tbl_size[m][pos-1] == blk;
                    if (!join_pred && !join_succ && n >= TABLE_DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        res.status = ST_OK;
                        if (join_succ)
                        begin
                            hs = hs + tbl_size[m][pos];
                            tbl_addr[m][pos] = blk;
                            tbl_size[m][pos] = hs & ADDR_MASK;
                        end
                        if (join_pred)
                        begin
                            tbl_size[m][pos-1] = (tbl_size[m][pos-1] + hs) & ADDR_MASK;
                            if (join_succ)
                                table_remove(m, pos);
                        end
                        else if (!join_succ)
                        begin
                            for (i = n; i > pos; i--)
                            begin
                                tbl_addr[m][i] = tbl_addr[m][i-1];
                                tbl_size[m][i] = tbl_size[m][i-1];
                            end
                            tbl_addr[m][pos] = blk;
                            tbl_size[m][pos] = hs & ADDR_MASK;
                            tbl_count[m]++;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic ffa_req_t alloc_req(logic [31:0] bytes);
        ffa_req_t r;
        r.op = OP_ALLOC;
        r.request_size = bytes;
        r.user_address = $urandom;
        r.header_size = $urandom;
        return r;
    endfunction

    function automatic ffa_req_t free_req(logic [31:0] uaddr, logic [31:0] hsize);
        ffa_req_t r;
        r.op = OP_FREE;
        r.request_size = $urandom;
        r.user_address = uaddr;
        r.header_size = hsize;
        return r;
    endfunction

    task automatic queue_request(input ffa_req_t r, output ffa_rsp_t res);
        res = first_fit_outcome(PLAN_COPY, r);
        if (r.op == OP_ALLOC && res.status == ST_OK)
        begin
            live_addr.push_back(res.granted_address);
            live_size.push_back(res.granted_size);
        end
        pending_requests.push_back(r);
    endtask

    task automatic free_live(input int k, input logic [31:0] hsize);
        ffa_rsp_t    res;
        logic [31:0] ua;
        ua = live_addr[k];
        queue_request(free_req(ua, hsize), res);
        if (res.status == ST_OK)
        begin
            live_addr.delete(k);
            live_size.delete(k);
            freed_addrs.push_back(ua);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        int m;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        for (m = 0; m < 2; m++)
        begin
            if (idx == REG_START)
            begin
                reg_start[m] = val;
                table_rebuild(m);
            end
            else if (idx == REG_SIZE)
            begin
                reg_size[m] = val;
                table_rebuild(m);
            end
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_grants.size() != 0);
    endtask

    task automatic begin_phase(input logic [31:0] start, input logic [31:0] bytes);
        wait_idle();
        write_reg(REG_START, start);
        write_reg(REG_SIZE, bytes);
        live_addr.delete();
        live_size.delete();
        freed_addrs.delete();
        settings_run++;
        @(negedge clk);
    endtask

    task automatic run_random_phase(input logic [31:0] start, input logic [31:0] bytes,
                                    input bit fragment);
        ffa_rsp_t    res;
        int          j, k, pick;
        logic [31:0] want;
        begin_phase(start, bytes);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE_B, $urandom);
        if (fragment)
        begin
            for (j = 0; j < 36; j++)
                queue_request(alloc_req($urandom_range(1, 24)), res);
            for (j = 35; j >= 1; j -= 2)
                if (j < live_addr.size())
                    free_live(j, live_size[j]);
        end
        for (j = 0; j < PHASE_ITEMS; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || (live_addr.size() == 0 && pick < 85))
            begin
                k = $urandom_range(0, 99);
                if (k < 80)
                    want = $urandom_range(0, 64);
                else if (k < 92)
                    want = $urandom_range(0, bytes);
                else
                    want = $urandom;
                queue_request(alloc_req(want), res);
            end
            else if (pick < 85)
            begin
                k = $urandom_range(0, live_addr.size() - 1);
                free_live(k, live_size[k]);
            end
            else if (pick < 90 && freed_addrs.size() > 0)
                queue_request(free_req(freed_addrs[$urandom_range(0, freed_addrs.size() - 1)],
                                       $urandom), res);
            else if (pick < 95 && live_addr.size() > 0)
            begin
                k = $urandom_range(0, live_addr.size() - 1);
                free_live(k, $urandom_range(0, 1) ? live_size[k] + 8 : $urandom);
            end
            else
                queue_request(free_req($urandom_range(0, 1) ? $urandom
                                           : start + $urandom_range(0, bytes + 16),
                                       $urandom_range(0, 1) ? $urandom
                                           : 8 * $urandom_range(1, 8) + 4), res);
        end
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        ffa_rsp_t res;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                res = first_fit_outcome(CHECK_COPY, req);
                expected_grants.push_back(res);
                outcome_tally[res.status]++;
                if (req.op == OP_ALLOC)
                    alloc_total++;
                else
                    free_total++;
            end
            if (!(req_valid && !req_ready))
            begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= req_idle_pct)
                begin
                    req <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s at cycle %0d: expected %h, got %h",
                     field, cycle_count, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        ffa_rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (expected_grants.size() == 0)
                    report_mismatch("unexpected result status", '0, 32'(rsp.status));
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(rsp.status));
                    if (rsp.granted_address !== want.granted_address)
                        report_mismatch("granted_address", want.granted_address,
                                        rsp.granted_address);
                    if (rsp.granted_size !== want.granted_size)
                        report_mismatch("granted_size", want.granted_size, rsp.granted_size);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    initial
    begin : stimulus
        ffa_rsp_t    res;
        logic [31:0] probe;
        int          p;
        logic [31:0] start, bytes;
        reg_start[PLAN_COPY] = '0;
        reg_size[PLAN_COPY] = '0;
        reg_start[CHECK_COPY] = '0;
        reg_size[CHECK_COPY] = '0;
        table_rebuild(PLAN_COPY);
        table_rebuild(CHECK_COPY);

        queue_request(alloc_req(32'd0), res);
        queue_request(free_req(32'd12, 32'd12), res);

        begin_phase(32'h1000, 32'h1000);
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h0);
        queue_request(alloc_req(32'd0), res);
        queue_request(alloc_req(32'd1), res);
        queue_request(alloc_req(32'd8), res);
        queue_request(alloc_req(32'd9), res);
        queue_request(alloc_req(32'hFFFF_FFFF), res);
        queue_request(alloc_req(32'hFFFF_FFF9), res);
        probe = live_addr[1];
        free_live(1, live_size[1]);
        queue_request(free_req(probe, 32'd12), res);
        free_live(0, live_size[0]);
        free_live(0, live_size[0]);
        queue_request(free_req(32'h1008, 32'd12), res);
        queue_request(free_req(32'h2004, 32'd12), res);
        queue_request(free_req(32'h0, 32'hFFFF_FFFF), res);
        queue_request(free_req(32'h2003, 32'd12), res);
        queue_request(alloc_req(32'd40), res);
        free_live(1, live_size[1] + 64);
        free_live(0, live_size[0]);

        begin_phase(32'h20, 32'd16);
        queue_request(alloc_req(32'd0), res);
        begin_phase(32'h20, 32'd17);
        queue_request(alloc_req(32'd0), res);

        begin_phase(32'h100, 32'd28);
        queue_request(alloc_req(32'd8), res);
        queue_request(alloc_req(32'd1), res);
        free_live(0, live_size[0]);

        begin_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(alloc_req(32'd16), res);
        free_live(0, live_size[0]);

        begin_phase(32'h0, 32'hFFFF_FFFF);
        queue_request(alloc_req(32'hFFFF_FFF0), res);
        free_live(0, live_size[0]);

        for (p = 0; p < 12; p++)
        begin
            case (p % 4)
                0: start = $urandom & 32'hFFFF_FFF8;
                1: start = $urandom;
                2: start = 32'h0;
                default: start = $urandom_range(0, 255) * 8;
            endcase
            if (p == 3)
                bytes = $urandom_range(17, 64);
            else if (p == 7)
                bytes = $urandom;
            else
                bytes = $urandom_range(32'h200, 32'h4000);
            req_idle_pct = (p == 5) ? 0 : 20;
            rsp_idle_pct = (p == 5) ? 0 : 20;
            run_random_phase(start, bytes, (p % 3 == 1) && bytes >= 32'h800);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Ran %0d requests (%0d allocate, %0d free) over %0d region settings,",
                 alloc_total + free_total, alloc_total, free_total, settings_run);
        $display("  outcomes: %0d ok, %0d no fit, %0d out of range, %0d full, %0d double free",
                 outcome_tally[ST_OK], outcome_tally[ST_NOFIT], outcome_tally[ST_RANGE],
                 outcome_tally[ST_FULL], outcome_tally[ST_DOUBLE]);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
